>>> design/rsc_pkg.sv
`default_nettype none

package rsc_pkg;

   localparam int DEFAULT_STACK_DEPTH = 16;
   localparam int DEFAULT_FRAC_BITS   = 32;

   localparam int WORD_W   = 64;
   localparam int DEPTH_W  = 5;
   localparam int OPCODE_W = 3;
   localparam int STATUS_W = 3;
   // Wide enough for the highest numerator bit index the divider can start from.
   localparam int IDX_W    = 7;

   localparam logic [WORD_W-1:0] SIGN64 = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic [WORD_W-1:0] MAXPOS = {1'b0, {(WORD_W-1){1'b1}}};

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH    = 3'd0,
      OP_ADD     = 3'd1,
      OP_SUB     = 3'd2,
      OP_MUL     = 3'd3,
      OP_DIV     = 3'd4,
      OP_SWAP    = 3'd5,
      OP_UNKNOWN = 3'd6
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_UNDERFLOW = 3'd1,
      STAT_OVERFLOW  = 3'd2,
      STAT_DIV_ZERO  = 3'd3,
      STAT_UNKNOWN   = 3'd4,
      STAT_SATURATED = 3'd5
   } status_type;

endpackage

`default_nettype wire

>>> design/rpn_stack_calculator.sv
`default_nettype none

// Channel    | Direction | Ports                   | Contents (lowest bit first)
// -----------+-----------+-------------------------+-------------------------------------
// request    | in        | req_tvalid/tready/tdata | tuser: opcode[2:0]; tdata: literal[63:0]
// response   | out       | rsp_tvalid/tready/tdata | tuser: status[2:0];
//            |           |                         | tdata: top_value[63:0], depth[68:64]
//
// Push, unknown opcodes and every underflow or overflow respond straight from idle;
// add, subtract and divide by zero go through the load state, swap through load and
// swap2. Multiply goes through load, multiply and sign, making four passes through
// one 32 x 32 multiplier; divide (Q32.32 by default) goes through load, divide and
// sign, set by the restoring divider that retires two quotient bits per cycle.
// Reset is synchronous and empties the stack; the value store itself is not cleared.
// A new request is taken only while the sequencer is idle and the response register
// is empty or being emptied in the same cycle, so a stalled response holds the block.

module rpn_stack_calculator
   import rsc_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
   parameter int FRAC_BITS   = DEFAULT_FRAC_BITS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [63:0]   req_tdata,   // literal[63:0]
   input  wire logic [2:0]    req_tuser,   // opcode[2:0]
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [71:0]        rsp_tdata,   // top_value[63:0], depth[68:64], zero fill
   output logic [2:0]         rsp_tuser    // status[2:0]
);

   localparam int SP_W   = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   // The divider starts at the highest numerator bit that can be set, rounded so that
   // an even number of bits is processed; the extra top bit is always zero.
   localparam int DIV_START = 63 + FRAC_BITS + (FRAC_BITS % 2);
   localparam int NUM_SHIFT = 64 - (FRAC_BITS % 2);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SWAP2,
      ST_MUL,
      ST_DIV,
      ST_SIGN
   } state_type;

   // One restoring division step: shift in a numerator bit, subtract the divisor
   // when it fits. The remainder is always below the divisor, so 65 bits suffice.
   function automatic logic [64:0] div_step(input logic [63:0] rem,
                                            input logic        nbit,
                                            input logic [63:0] dvs);
      logic [64:0] shifted;
      logic [64:0] diff;
      shifted = {rem, nbit};
      diff    = shifted - {1'b0, dvs};
      if (!diff[64]) begin
         div_step = {1'b1, diff[63:0]};
      end else begin
         div_step = {1'b0, shifted[63:0]};
      end
   endfunction

   // Stack storage: the top entry is mirrored in top_ff so that only the next
   // entry needs a memory read.
   logic [WORD_W-1:0]   mem [STACK_DEPTH];
   logic [WORD_W-1:0]   rd_data_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [WORD_W-1:0]   wr_data;

   state_type           state_ff, state_in;
   logic [SP_W-1:0]     sp_ff, sp_in;
   logic [WORD_W-1:0]   top_ff, top_in;
   opcode_type          op_ff, op_in;
   logic [WORD_W-1:0]   a_ff, a_in;
   logic [WORD_W-1:0]   x_ff, x_in;
   logic [WORD_W-1:0]   y_ff, y_in;
   logic                neg_ff, neg_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic [63:0]         prod_ff, prod_in;
   logic [1:0]          psh_ff, psh_in;
   logic [127:0]        acc_ff, acc_in;
   logic [127:0]        num_ff, num_in;
   logic [63:0]         rem_ff, rem_in;
   logic [63:0]         q_ff, q_in;
   logic                big_ff, big_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;

   logic                rsp_tvalid_ff, rsp_tvalid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]   rsp_top_ff, rsp_top_in;
   logic [DEPTH_W-1:0]  rsp_depth_ff, rsp_depth_in;
   logic                rsp_load;

   logic                req_xfer;
   opcode_type          req_op;
   logic [ADDR_W-1:0]   push_addr;
   logic [ADDR_W-1:0]   top_addr;
   logic [ADDR_W-1:0]   pop_addr;
   logic [WORD_W-1:0]   err_top;
   logic [WORD_W-1:0]   t_val;
   logic [WORD_W-1:0]   n_val;
   logic                is_sub;
   logic [WORD_W-1:0]   sum;
   logic                sum_ovf;
   logic [WORD_W-1:0]   sum_res;
   logic [WORD_W-1:0]   mag_t;
   logic [WORD_W-1:0]   mag_n;
   logic [31:0]         mul_xs;
   logic [31:0]         mul_ys;
   logic [127:0]        prod_ext;
   logic [127:0]        mul_shifted;
   logic [64:0]         step1;
   logic [64:0]         step2;
   logic [WORD_W-1:0]   fin_mag;
   logic                fin_big;
   logic [WORD_W-1:0]   fin_lim;
   logic                fin_sat;
   logic [WORD_W-1:0]   fin_res;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_tvalid_ff || rsp_tready);
   assign req_xfer   = req_tvalid && req_tready;
   assign req_op     = opcode_type'(req_tuser);

   assign push_addr = ADDR_W'(sp_ff);
   assign top_addr  = ADDR_W'(sp_ff - SP_W'(1));
   assign pop_addr  = ADDR_W'(sp_ff - SP_W'(2));
   assign rd_addr   = pop_addr;
   assign err_top   = (sp_ff != '0) ? top_ff : '0;

   // Shared add/subtract for the add and subtract ops: T + N or T - N, with saturation.
   assign t_val   = top_ff;
   assign n_val   = rd_data_ff;
   assign is_sub  = (op_ff == OP_SUB);
   assign sum     = t_val + (is_sub ? ~n_val : n_val) + WORD_W'(is_sub);
   assign sum_ovf = ((t_val[63] ^ n_val[63]) == is_sub) && (sum[63] != t_val[63]);
   assign sum_res = sum_ovf ? (t_val[63] ? SIGN64 : MAXPOS) : sum;

   assign mag_t = t_val[63] ? (~t_val + WORD_W'(1)) : t_val;
   assign mag_n = n_val[63] ? (~n_val + WORD_W'(1)) : n_val;

   // Partial products in the order x0*y0, x0*y1, x1*y0, x1*y1.
   assign mul_xs = cnt_ff[1] ? x_ff[63:32] : x_ff[31:0];
   assign mul_ys = cnt_ff[0] ? y_ff[63:32] : y_ff[31:0];

   always_comb begin
      case (psh_ff)
         2'd0:    prod_ext = {64'b0, prod_ff};
         2'd1:    prod_ext = {32'b0, prod_ff, 32'b0};
         default: prod_ext = {prod_ff, 64'b0};
      endcase
   end

   assign mul_shifted = acc_ff >> FRAC_BITS;

   assign step1 = div_step(rem_ff, num_ff[127], y_ff);
   assign step2 = div_step(step1[63:0], num_ff[126], y_ff);

   // Final sign and clamp for multiply and divide magnitudes.
   assign fin_mag = (op_ff == OP_MUL) ? mul_shifted[63:0] : q_ff;
   assign fin_big = (op_ff == OP_MUL) ? (|mul_shifted[127:64]) : big_ff;
   assign fin_lim = neg_ff ? SIGN64 : MAXPOS;
   assign fin_sat = fin_big || (fin_mag > fin_lim);
   assign fin_res = fin_sat ? fin_lim : (neg_ff ? (~fin_mag + WORD_W'(1)) : fin_mag);

   always_comb begin
      state_in      = state_ff;
      sp_in         = sp_ff;
      top_in        = top_ff;
      op_in         = op_ff;
      a_in          = a_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      neg_in        = neg_ff;
      cnt_in        = cnt_ff;
      prod_in       = {32'b0, mul_xs} * {32'b0, mul_ys};
      psh_in        = 2'(cnt_ff[1]) + 2'(cnt_ff[0]);
      acc_in        = acc_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      q_in          = q_ff;
      big_in        = big_ff;
      idx_in        = idx_ff;
      rsp_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_depth_in  = rsp_depth_ff;
      wr_en         = 1'b0;
      wr_addr       = pop_addr;
      wr_data       = fin_res;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               op_in = req_op;
               unique case (req_op) inside
                  OP_PUSH: begin
                     rsp_load = 1'b1;
                     if (sp_ff >= SP_W'(STACK_DEPTH)) begin
                        rsp_status_in = STAT_OVERFLOW;
                        rsp_top_in    = err_top;
                        rsp_depth_in  = DEPTH_W'(sp_ff);
                     end else begin
                        wr_en         = 1'b1;
                        wr_addr       = push_addr;
                        wr_data       = req_tdata;
                        top_in        = req_tdata;
                        sp_in         = sp_ff + SP_W'(1);
                        rsp_status_in = STAT_OK;
                        rsp_top_in    = req_tdata;
                        rsp_depth_in  = DEPTH_W'(sp_ff + SP_W'(1));
                     end
                  end
                  OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP: begin
                     if (sp_ff < SP_W'(2)) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = STAT_UNDERFLOW;
                        rsp_top_in    = err_top;
                        rsp_depth_in  = DEPTH_W'(sp_ff);
                     end else begin
                        state_in = ST_LOAD;
                     end
                  end
                  default: begin
                     rsp_load      = 1'b1;
                     rsp_status_in = STAT_UNKNOWN;
                     rsp_top_in    = err_top;
                     rsp_depth_in  = DEPTH_W'(sp_ff);
                  end
               endcase
            end
         end

         ST_LOAD: begin
            // The next entry has arrived from the memory; the top is in top_ff.
            a_in   = t_val;
            x_in   = mag_t;
            y_in   = mag_n;
            neg_in = t_val[63] ^ n_val[63];
            unique case (op_ff) inside
               OP_ADD, OP_SUB: begin
                  wr_en         = 1'b1;
                  wr_data       = sum_res;
                  top_in        = sum_res;
                  sp_in         = sp_ff - SP_W'(1);
                  rsp_load      = 1'b1;
                  rsp_status_in = sum_ovf ? STAT_SATURATED : STAT_OK;
                  rsp_top_in    = sum_res;
                  rsp_depth_in  = DEPTH_W'(sp_ff - SP_W'(1));
                  state_in      = ST_IDLE;
               end
               OP_SWAP: begin
                  wr_en    = 1'b1;
                  wr_addr  = top_addr;
                  wr_data  = n_val;
                  top_in   = n_val;
                  state_in = ST_SWAP2;
               end
               OP_MUL: begin
                  cnt_in   = '0;
                  acc_in   = '0;
                  state_in = ST_MUL;
               end
               default: begin
                  if (n_val == '0) begin
                     // Divide by zero: pop both and push the limit of the sign of T.
                     wr_en         = 1'b1;
                     wr_data       = t_val[63] ? SIGN64 : MAXPOS;
                     top_in        = wr_data;
                     sp_in         = sp_ff - SP_W'(1);
                     rsp_load      = 1'b1;
                     rsp_status_in = STAT_DIV_ZERO;
                     rsp_top_in    = wr_data;
                     rsp_depth_in  = DEPTH_W'(sp_ff - SP_W'(1));
                     state_in      = ST_IDLE;
                  end else begin
                     rem_in   = '0;
                     q_in     = '0;
                     big_in   = 1'b0;
                     num_in   = 128'(mag_t) << NUM_SHIFT;
                     idx_in   = IDX_W'(DIV_START);
                     state_in = ST_DIV;
                  end
               end
            endcase
         end

         ST_SWAP2: begin
            wr_en         = 1'b1;
            wr_addr       = pop_addr;
            wr_data       = a_ff;
            rsp_load      = 1'b1;
            rsp_status_in = STAT_OK;
            rsp_top_in    = top_ff;
            rsp_depth_in  = DEPTH_W'(sp_ff);
            state_in      = ST_IDLE;
         end

         ST_MUL: begin
            // Products issued at counts 0 to 3 are registered in prod_ff and added at counts 1 to 4.
            if (cnt_ff != '0) begin
               acc_in = acc_ff + prod_ext;
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               state_in = ST_SIGN;
            end
         end

         ST_DIV: begin
            rem_in = step2[63:0];
            q_in   = {q_ff[61:0], step1[64], step2[64]};
            // A quotient bit at position 64 or above means the result cannot fit.
            big_in = big_ff || (step1[64] && idx_ff[6]) ||
                     (step2[64] && (idx_ff > IDX_W'(64)));
            num_in = num_ff << 2;
            idx_in = idx_ff - IDX_W'(2);
            if (idx_ff == IDX_W'(1)) begin
               state_in = ST_SIGN;
            end
         end

         ST_SIGN: begin
            wr_en         = 1'b1;
            wr_data       = fin_res;
            top_in        = fin_res;
            sp_in         = sp_ff - SP_W'(1);
            rsp_load      = 1'b1;
            rsp_status_in = fin_sat ? STAT_SATURATED : STAT_OK;
            rsp_top_in    = fin_res;
            rsp_depth_in  = DEPTH_W'(sp_ff - SP_W'(1));
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sp_ff         <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sp_ff         <= sp_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      top_ff        <= top_in;
      op_ff         <= op_in;
      a_ff          <= a_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      neg_ff        <= neg_in;
      cnt_ff        <= cnt_in;
      prod_ff       <= prod_in;
      psh_ff        <= psh_in;
      acc_ff        <= acc_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      q_ff          <= q_in;
      big_ff        <= big_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {3'b0, rsp_depth_ff, rsp_top_ff};
   assign rsp_tuser  = rsp_status_ff;

   // The stack pointer never runs past the storage.
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("stack pointer beyond stack depth");

   // A new result is never loaded over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("response register overwritten");

   // Requests are only taken by an idle sequencer.
   a_busy_no_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("request accepted while busy");

   // Multiply and divide leave one entry fewer.
   a_sign_pops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIGN) |=> (sp_ff == $past(sp_ff) - SP_W'(1)))
      else $error("stack pointer wrong after arithmetic result");

   // The divider always works on pairs ending at bit zero.
   a_div_odd_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> idx_ff[0])
      else $error("divider bit index out of step");

endmodule

`default_nettype wire

>>> test/stack_result_checker.sv
`default_nettype none

module stack_result_checker
   import rsc_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
   parameter int FRAC_BITS   = DEFAULT_FRAC_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [63:0] req_tdata,   // literal[63:0]
   input  wire logic [2:0]  req_tuser,   // opcode[2:0]
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [71:0] rsp_tdata,   // top_value[63:0], depth[68:64], zero fill
   input  wire logic [2:0]  rsp_tuser,   // status[2:0]
   output int               failures,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      status_type  status;
      logic [63:0] top_value;
      logic [4:0]  depth;
   } stack_result_type;

   // Private copy of the stack, advanced once per accepted request.
   logic [63:0]      stack_copy [STACK_DEPTH];
   int               stack_count = 0;
   stack_result_type expected_results [$];
   int               fail_count = 0;

   function automatic logic [63:0] abs_word(input logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

   // Give a sign to an exact magnitude, clamping to the signed limit of that sign.
   function automatic logic [63:0] clamp_magnitude(input logic neg, input logic [127:0] mag,
                                                   output logic sat);
      logic [63:0] lim;
      lim = neg ? SIGN64 : MAXPOS;
      sat = (mag > {64'd0, lim});
      if (sat)
         return lim;
      return neg ? (64'd0 - mag[63:0]) : mag[63:0];
   endfunction

   function automatic stack_result_type predict_step(input logic [2:0] opc,
                                                     input logic [63:0] lit);
      stack_result_type res;
      logic [63:0]      t, n, r, s;
      logic [127:0]     wide;
      logic             sat, neg;
      res.status = STAT_OK;
      sat = 1'b0;
      r = '0;
      case (opc)
         OP_PUSH: begin
            if (stack_count >= STACK_DEPTH) begin
               res.status = STAT_OVERFLOW;
            end else begin
               stack_copy[stack_count] = lit;
               stack_count++;
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP: begin
            if (stack_count < 2) begin
               res.status = STAT_UNDERFLOW;
            end else begin
               t = stack_copy[stack_count-1];
               n = stack_copy[stack_count-2];
               neg = t[63] ^ n[63];
               if (opc == OP_SWAP) begin
                  stack_copy[stack_count-1] = n;
                  stack_copy[stack_count-2] = t;
               end else begin
                  case (opc)
                     OP_ADD: begin
                        s = t + n;
                        sat = (t[63] == n[63]) && (s[63] != t[63]);
                        r = sat ? (t[63] ? SIGN64 : MAXPOS) : s;
                     end
                     OP_SUB: begin
                        s = t - n;
                        sat = (t[63] != n[63]) && (s[63] != t[63]);
                        r = sat ? (t[63] ? SIGN64 : MAXPOS) : s;
                     end
                     OP_MUL: begin
                        wide = ({64'd0, abs_word(t)} * {64'd0, abs_word(n)}) >> FRAC_BITS;
                        r = clamp_magnitude(neg, wide, sat);
                     end
                     default: begin
                        if (n == '0) begin
                           // Division by zero gives the limit on the side of the dividend.
                           r = t[63] ? SIGN64 : MAXPOS;
                           res.status = STAT_DIV_ZERO;
                        end else begin
                           wide = ({64'd0, abs_word(t)} << FRAC_BITS) / {64'd0, abs_word(n)};
                           r = clamp_magnitude(neg, wide, sat);
                        end
                     end
                  endcase
                  if (sat && res.status == STAT_OK)
                     res.status = STAT_SATURATED;
                  stack_copy[stack_count-2] = r;
                  stack_count--;
               end
            end
         end
         default: res.status = STAT_UNKNOWN;
      endcase
      res.top_value = (stack_count != 0) ? stack_copy[stack_count-1] : '0;
      res.depth     = 5'(stack_count);
      return res;
   endfunction

   always @(posedge clock) begin : watch_channels
      stack_result_type want;
      if (reset) begin
         stack_count = 0;
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               $error("response transfer with no request outstanding");
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser !== want.status) begin
                  fail_count++;
                  $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               end
               if (rsp_tdata[63:0] !== want.top_value) begin
                  fail_count++;
                  $error("top_value: expected %h, actual %h", want.top_value,
                         rsp_tdata[63:0]);
               end
               if (rsp_tdata[68:64] !== want.depth) begin
                  fail_count++;
                  $error("depth: expected %0d, actual %0d", want.depth, rsp_tdata[68:64]);
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_step(req_tuser, req_tdata));
      end
      pending  <= expected_results.size();
      failures <= fail_count;
   end

endmodule

`default_nettype wire

>>> test/tb_top.sv
`default_nettype none

module tb_top;
   import rsc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // The opcode field is three bits wide, so one code is left unassigned; the block must
   // treat it like an unknown name.
   localparam logic [2:0]  OPC_UNASSIGNED = 3'd7;

   localparam logic [63:0] Q_ONE       = 64'h0000_0001_0000_0000;
   localparam logic [63:0] Q_MINUS_ONE = 64'hFFFF_FFFF_0000_0000;
   localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam int STACK_DEPTH_TB = DEFAULT_STACK_DEPTH;

   // The receiver's long hold-off; far more than one response register can absorb.
   localparam int HOLD_OFF_CYCLES = 400;
   // Covers the slowest request, a divide at Q32.32, with room.
   localparam int END_MARGIN      = 64;
   // No transfer at all for this long means the block has locked up. The quietest
   // correct stretch is the hold-off plus one divide plus a tail of receiver idling.
   localparam int WATCHDOG_LIMIT  = 4000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;    // literal[63:0]
   logic [2:0]  req_tuser  = OP_PUSH;   // opcode[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;          // top_value[63:0], depth[68:64], zero fill
   logic [2:0]  rsp_tuser;          // status[2:0]

   int result_failures;
   int results_pending;

   // Idling rates in percent. The sender's rate is read only by the stimulus process.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int          hold_off_requests = 0;
   int          hold_off_served   = 0;
   int          hold_off_left     = 0;
   int          idle_cycles       = 0;
   // Rough depth of the stack as the stimulus sees it, used only to steer the sequences.
   int          stack_level       = 0;

   always #5 clock = ~clock;

   rpn_stack_calculator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   stack_result_checker result_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .failures   (result_failures),
      .pending    (results_pending)
   );

   // Receiver. It idles at random at its current rate, except while a long hold-off is
   // running; the hold-off is counted here so that the sender keeps offering transfers
   // meanwhile and the block fills up and stalls its request side.
   always @(posedge clock) begin
      if (hold_off_left != 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_tready    <= 1'b0;
      end else if (hold_off_served != hold_off_requests) begin
         hold_off_served <= hold_off_requests;
         hold_off_left   <= HOLD_OFF_CYCLES - 1;
         rsp_tready      <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // Literals lean towards the limits, zero (so that divides by zero are common) and small
   // numbers with fractions, which keep most arithmetic out of saturation.
   function automatic logic [63:0] random_literal();
      logic [63:0] v;
      case ($urandom_range(9))
         0:       v = '0;
         1:       v = MAXPOS;
         2:       v = SIGN64;
         3:       v = ALL_ONES;
         4, 5:    v = {$urandom, $urandom};
         9:       v = {28'd0, 4'($urandom_range(15)), 32'd0};
         default: v = {28'd0, 4'($urandom_range(15)), 32'($urandom)};
      endcase
      if ($urandom_range(1) == 1 && v[63] == 1'b0)
         v = 64'd0 - v;
      return v;
   endfunction

   // Offers one request and returns at the edge where it is transferred. Ready is read
   // straight after the edge, before any of that step's updates have landed.
   task automatic send_item(input logic [2:0] opc, input logic [63:0] lit);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= opc;
      req_tdata  <= lit;
      do @(posedge clock); while (req_tready !== 1'b1);
      case (opc)
         OP_PUSH: if (stack_level < STACK_DEPTH_TB) stack_level++;
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: if (stack_level >= 2) stack_level--;
         default: ;
      endcase
   endtask

   // The sender stops and waits until every expected response has been transferred.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
   endtask

   // One phase of random traffic. Most of it is well-formed: pushes interleaved with
   // arithmetic once two entries are held. Now and then the stack is filled past its
   // depth to provoke overflow, and a tenth of the items are noise with any opcode.
   task automatic run_phase(input int items, input int unsigned sender_pct,
                            input int unsigned receiver_pct, input bit with_hold_off);
      int          sent;
      int          burst;
      int unsigned roll;
      bit          held;
      logic [2:0]  opc;
      send_idle_pct = sender_pct;
      recv_idle_pct <= receiver_pct;
      sent = 0;
      held = 1'b0;
      while (sent < items) begin
         if (with_hold_off && !held && sent >= items / 2) begin
            hold_off_requests <= hold_off_requests + 1;
            held = 1'b1;
         end
         roll = $urandom_range(99);
         if (roll < 2) begin
            burst = STACK_DEPTH_TB + 2 - stack_level;
            repeat (burst) begin
               send_item(OP_PUSH, random_literal());
               sent++;
            end
         end else if (roll < 12) begin
            send_item(3'($urandom_range(7)), {$urandom, $urandom});
            sent++;
         end else if (stack_level < 2 || roll < 50) begin
            send_item(OP_PUSH, random_literal());
            sent++;
         end else begin
            case ($urandom_range(4))
               0:       opc = OP_ADD;
               1:       opc = OP_SUB;
               2:       opc = OP_MUL;
               3:       opc = OP_DIV;
               default: opc = OP_SWAP;
            endcase
            send_item(opc, {$urandom, $urandom});
            sent++;
         end
      end
      drain_results();
   endtask

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 28;
      recv_idle_pct <= 84;

      // Directed part. Underflow on an empty stack and on a single entry.
      send_item(OP_ADD, '0);
      send_item(OP_SWAP, ALL_ONES);
      send_item(OP_PUSH, MAXPOS);
      send_item(OP_MUL, '0);
      // Add past the positive limit, then subtract past the negative one.
      send_item(OP_PUSH, 64'd1);
      send_item(OP_ADD, '0);
      send_item(OP_PUSH, SIGN64);
      send_item(OP_SUB, '0);
      // Divide by zero with a negative dividend, then with a positive one.
      send_item(OP_PUSH, '0);
      send_item(OP_SWAP, '0);
      send_item(OP_DIV, '0);
      send_item(OP_PUSH, '0);
      send_item(OP_PUSH, 64'h0000_0005_8000_0000);
      send_item(OP_DIV, '0);
      // Multiply of the two limits saturates negative.
      send_item(OP_MUL, '0);
      // Minus one divided by the most negative value, then a product that truncates to zero.
      send_item(OP_PUSH, Q_MINUS_ONE);
      send_item(OP_DIV, '0);
      send_item(OP_PUSH, ALL_ONES);
      send_item(OP_MUL, '0);
      // An unknown name and the unassigned code leave the stack alone.
      send_item(OP_UNKNOWN, ALL_ONES);
      send_item(OPC_UNASSIGNED, '0);
      send_item(OP_PUSH, Q_ONE);
      send_item(OP_MUL, '0);
      drain_results();

      // Random part: a slow receiver, then a slow sender, then no idling at all with one
      // long receiver hold-off in the middle.
      run_phase(600, 28, 84, 1'b0);
      run_phase(600, 84, 28, 1'b0);
      run_phase(620, 0, 0, 1'b1);

      repeat (END_MARGIN) @(posedge clock);
      if (result_failures == 0 && results_pending == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
design/rsc_pkg.sv
design/rpn_stack_calculator.sv
test/stack_result_checker.sv
test/tb_top.sv
